// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; users supply clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that an antecedent implies a consequent sequence.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/uwd_pkg.sv =====
// Types and constants for the terminal display width block.
// Depends on nothing; imported by the decoder step and the top level.
`default_nettype none

package uwd_pkg;

	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_ESC  = 3'b010,
		MODE_CSI  = 3'b100
	} mode_t;

	typedef logic [20:0] cp_t;
	typedef logic [1:0]  cw_t;
	typedef logic [3:0]  inc_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  seq_len;
		logic [2:0]  taken;
		cp_t         cp;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		mode:    MODE_TEXT,
		seq_len: 3'd0,
		taken:   3'd0,
		cp:      21'd0
	};

	localparam logic [7:0]  ESC_BYTE    = 8'h1B;
	localparam logic [7:0]  CSI_BYTE    = 8'h5B;
	localparam logic [7:0]  KEEP_OPEN_A = 8'h28;
	localparam logic [7:0]  KEEP_OPEN_B = 8'h29;
	localparam logic [7:0]  FINAL_LO    = 8'h40;
	localparam logic [7:0]  FINAL_HI    = 8'h7E;

	localparam cp_t CP_MAX     = 21'h10FFFF;
	localparam cp_t SURR_LO    = 21'h00D800;
	localparam cp_t SURR_HI    = 21'h00DFFF;
	localparam cp_t LEAST_TWO  = 21'h000080;
	localparam cp_t LEAST_THR  = 21'h000800;
	localparam cp_t LEAST_FOUR = 21'h010000;

	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== sv/uwd_cell_width.sv =====
// Terminal cell width (0, 1 or 2) of one code point.
// Depends on uwd_pkg for the code point and width types.
`default_nettype none

module uwd_cell_width
	import uwd_pkg::*;
(
	input  wire cp_t cp,
	output cw_t      width
);

	function automatic logic in_rng(input cp_t v, input cp_t lo, input cp_t hi);
		in_rng = (v >= lo) && (v <= hi);
	endfunction

	logic is_ctrl;
	logic is_comb;
	logic is_wide;

	assign is_ctrl = (cp < 21'h20) || in_rng(cp, 21'h7F, 21'h9F);

	// combining marks and variation selectors
	assign is_comb = in_rng(cp, 21'h0300, 21'h036F) || in_rng(cp, 21'h1AB0, 21'h1AFF)
		|| in_rng(cp, 21'h1DC0, 21'h1DFF) || in_rng(cp, 21'h20D0, 21'h20FF)
		|| in_rng(cp, 21'hFE00, 21'hFE0F) || in_rng(cp, 21'hFE20, 21'hFE2F)
		|| in_rng(cp, 21'hE0100, 21'hE01EF);

	// East Asian wide and emoji blocks
	assign is_wide = in_rng(cp, 21'h1100, 21'h115F) || in_rng(cp, 21'h2329, 21'h232A)
		|| in_rng(cp, 21'h2E80, 21'hA4CF) || in_rng(cp, 21'hAC00, 21'hD7A3)
		|| in_rng(cp, 21'hF900, 21'hFAFF) || in_rng(cp, 21'hFE10, 21'hFE19)
		|| in_rng(cp, 21'hFE30, 21'hFE6F) || in_rng(cp, 21'hFF00, 21'hFF60)
		|| in_rng(cp, 21'hFFE0, 21'hFFE6) || in_rng(cp, 21'h1F000, 21'h1FAFF)
		|| in_rng(cp, 21'h20000, 21'h3FFFD);

	assign width = (is_ctrl || is_comb) ? 2'd0 : (is_wide ? 2'd2 : 2'd1);

endmodule

`default_nettype wire

// ===== sv/uwd_step.sv =====
// One byte of escape skipping and UTF-8 decoding: next state and width added.
// Depends on uwd_pkg and uwd_cell_width.
`default_nettype none

module uwd_step
	import uwd_pkg::*;
(
	input  wire dec_state_t cur,
	input  wire logic [7:0] text_byte,
	input  wire logic       last_byte,
	output dec_state_t      nxt,
	output inc_t            inc
);

	logic       seq_open;
	logic       cont;
	logic [2:0] taken_inc;
	cp_t        cp_shift;
	logic       finishing;
	cp_t        cp_sel;
	cw_t        cw;
	cp_t        least;
	logic       cp_bad;

	dec_state_t nxt_pre;
	logic [2:0] inc_seq;
	cw_t        inc_fresh;
	logic [2:0] inc_end;
	logic       fresh;

	assign seq_open  = cur.seq_len != 3'd0;
	assign cont      = text_byte[7:6] == 2'b10;
	assign taken_inc = cur.taken + 3'd1;
	assign cp_shift  = {cur.cp[14:0], text_byte[5:0]};
	assign finishing = seq_open && cont && (taken_inc >= cur.seq_len);
	assign cp_sel    = finishing ? cp_shift : {13'd0, text_byte};

	uwd_cell_width u_cw (
		.cp    (cp_sel),
		.width (cw)
	);

	always_comb begin
		unique case (cur.seq_len)
			3'd2:    least = LEAST_TWO;
			3'd3:    least = LEAST_THR;
			default: least = LEAST_FOUR;
		endcase
	end

	// overlong, out of range and surrogate forms
	assign cp_bad = (cp_shift < least) || (cp_shift > CP_MAX)
		|| ((cp_shift >= SURR_LO) && (cp_shift <= SURR_HI));

	always_comb begin
		nxt_pre   = cur;
		inc_seq   = 3'd0;
		inc_fresh = 2'd0;
		fresh     = 1'b0;
		if (seq_open) begin
			if (cont) begin
				nxt_pre.cp    = cp_shift;
				nxt_pre.taken = taken_inc;
				if (finishing) begin
					inc_seq         = cp_bad ? cur.seq_len : {1'b0, cw};
					nxt_pre.seq_len = 3'd0;
					nxt_pre.taken   = 3'd0;
					nxt_pre.cp      = '0;
				end
			end else begin
				// broken sequence: charge its bytes, then rerun the byte
				inc_seq = cur.taken;
				fresh   = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			nxt_pre.seq_len = 3'd0;
			nxt_pre.taken   = 3'd0;
			nxt_pre.cp      = '0;
			if (text_byte == ESC_BYTE) begin
				nxt_pre.mode = MODE_ESC;
			end else begin
				unique case (cur.mode)
					MODE_ESC: begin
						if (text_byte == CSI_BYTE) begin
							nxt_pre.mode = MODE_CSI;
						end else if (text_byte != KEEP_OPEN_A && text_byte != KEEP_OPEN_B) begin
							nxt_pre.mode = MODE_TEXT;
						end
					end
					MODE_CSI: begin
						if (text_byte != CSI_BYTE && text_byte >= FINAL_LO
								&& text_byte <= FINAL_HI) begin
							nxt_pre.mode = MODE_TEXT;
						end
					end
					default: begin
						nxt_pre.mode = MODE_TEXT;
						if (!text_byte[7]) begin
							inc_fresh = cw;
						end else if (text_byte[7:5] == 3'b110) begin
							nxt_pre.seq_len = 3'd2;
							nxt_pre.taken   = 3'd1;
							nxt_pre.cp      = {16'd0, text_byte[4:0]};
						end else if (text_byte[7:4] == 4'b1110) begin
							nxt_pre.seq_len = 3'd3;
							nxt_pre.taken   = 3'd1;
							nxt_pre.cp      = {17'd0, text_byte[3:0]};
						end else if (text_byte[7:3] == 5'b11110) begin
							nxt_pre.seq_len = 3'd4;
							nxt_pre.taken   = 3'd1;
							nxt_pre.cp      = {18'd0, text_byte[2:0]};
						end else begin
							inc_fresh = 2'd1;
						end
					end
				endcase
			end
		end
	end

	// a sequence left open at the end of the string counts a cell per byte
	assign inc_end = (last_byte && nxt_pre.seq_len != 3'd0) ? nxt_pre.taken : 3'd0;
	assign inc     = 4'(inc_seq) + 4'(inc_fresh) + 4'(inc_end);
	assign nxt     = last_byte ? STATE_RESET : nxt_pre;

endmodule

`default_nettype wire

// ===== sv/utf8_terminal_display_width.sv =====
// Top level of the terminal display width block.
// Depends on uwd_pkg and uwd_step (which holds uwd_cell_width).
`default_nettype none

// Takes one byte of a text string per cycle and returns the number of terminal
// columns the whole string occupies once the byte marked last_byte has gone by.
// ANSI escape sequences (ESC, optional CSI, final byte) take no columns; UTF-8 is
// fully validated and every byte of a bad or truncated sequence counts one column.
// Each byte is registered, then the decoder state and running sum are updated by
// one pass of logic into state registers, so the sustained rate is one byte per
// clock while the input is not stalled. A result is registered on out_valid once
// its last byte leaves the input register, and holds while out_stall is high;
// only a last byte that finds an unread result in the output register stalls the
// input. The running sum saturates at 2^SUM_BITS-1 and total_width at 65535.
module utf8_terminal_display_width
	import uwd_pkg::*;
#(
	parameter int SUM_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  text_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] total_width
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decoder state and running sum
	dec_state_t          st_q;
	logic [SUM_BITS-1:0] sum_q;

	// result register
	logic        out_valid_q;
	logic [15:0] total_q;

	dec_state_t          st_nxt;
	inc_t                inc;
	logic [SUM_BITS:0]   sum_ext;
	logic [SUM_BITS-1:0] sum_sat;
	logic                advance;
	logic                step_en;
	logic                accept;

	// advance the held byte unless it is a last byte facing a stalled result
	assign advance  = !(last_s1 && out_valid_q && out_stall);
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload only: hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	uwd_step u_step (
		.cur       (st_q),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (st_nxt),
		.inc       (inc)
	);

	// saturating add: the carry out means the sum passed its top
	assign sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(inc);
	assign sum_sat = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RESET;
			sum_q <= '0;
		end else if (step_en) begin
			st_q  <= st_nxt;
			sum_q <= last_s1 ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// clip a wide sum to the 16-bit result
	always_ff @(posedge clk) begin
		if (step_en && last_s1) begin
			total_q <= (sum_sat > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX : 16'(sum_sat);
		end
	end

	assign out_valid   = out_valid_q;
	assign total_width = total_q;

endmodule

`default_nettype wire

// ===== sv/uwd_checker.sv =====
// Port-level checks for the terminal display width block, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module uwd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        last_byte,
	input wire        out_valid,
	input wire        out_stall,
	input wire [15:0] total_width
);

	`ASSERT_IMPLIES(a_out_hold, out_valid && out_stall, ##1 (out_valid && $stable(total_width)), "result changed while stalled")
	`ASSERT_IMPLIES(a_no_stall_empty, !out_valid, !in_stall, "input stalled with empty output")
	`ASSERT_IMPLIES(a_last_gives_result, in_valid && !in_stall && last_byte, ##2 out_valid, "no result two cycles after last byte")
	`ASSERT_IMPLIES(a_result_has_cause, $rose(out_valid), $past(in_valid && !in_stall && last_byte, 2), "result without a last byte")

endmodule

bind utf8_terminal_display_width uwd_checker u_chk (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for utf8_terminal_display_width: directed table, then random strings.
// Depends on uwd_pkg (mode codes, byte and code point constants) and the block's RTL.
`timescale 1ns / 1ps

module tb_top
	import uwd_pkg::*;
();

	localparam int SUM_BITS = 16;
	localparam longint SUM_TOP = (64'd1 << SUM_BITS) - 1;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	// One byte word as the sender offers it; typed marks a hand-written total.
	typedef struct packed {
		logic [7:0]  b;
		logic        last;
		logic        typed;
		logic [15:0] val;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] total_width;

	utf8_terminal_display_width #(.SUM_BITS(SUM_BITS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.total_width(total_width)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	word_t       word_q[$];
	word_t       cur_word;
	logic [15:0] width_q[$];
	int          err_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_ask = 0;
	int          hold_served = 0;
	int          hold_left = 0;

	// Predictor state: escape tracking, the open UTF-8 sequence, running column sum.
	mode_t       txt_mode = MODE_TEXT;
	logic [2:0]  seq_len = 3'd0;
	logic [2:0]  seq_got = 3'd0;
	cp_t         seq_cp = '0;
	longint      col_sum = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic bit in_span(input cp_t v, input cp_t lo, input cp_t hi);
		return v >= lo && v <= hi;
	endfunction

	// Terminal cells taken by one valid code point.
	function automatic int cell_cols(input cp_t cp);
		if (cp < 21'h20 || in_span(cp, 21'h7F, 21'h9F))
			return 0;
		if (in_span(cp, 21'h0300, 21'h036F) || in_span(cp, 21'h1AB0, 21'h1AFF) ||
				in_span(cp, 21'h1DC0, 21'h1DFF) || in_span(cp, 21'h20D0, 21'h20FF) ||
				in_span(cp, 21'hFE00, 21'hFE0F) || in_span(cp, 21'hFE20, 21'hFE2F) ||
				in_span(cp, 21'hE0100, 21'hE01EF))
			return 0;
		if (in_span(cp, 21'h1100, 21'h115F) || in_span(cp, 21'h2329, 21'h232A) ||
				in_span(cp, 21'h2E80, 21'hA4CF) || in_span(cp, 21'hAC00, 21'hD7A3) ||
				in_span(cp, 21'hF900, 21'hFAFF) || in_span(cp, 21'hFE10, 21'hFE19) ||
				in_span(cp, 21'hFE30, 21'hFE6F) || in_span(cp, 21'hFF00, 21'hFF60) ||
				in_span(cp, 21'hFFE0, 21'hFFE6) || in_span(cp, 21'h1F000, 21'h1FAFF) ||
				in_span(cp, 21'h20000, 21'h3FFFD))
			return 2;
		return 1;
	endfunction

	// Add columns, saturating at the top of the sum register.
	task automatic add_cols(input int unsigned w);
		col_sum = col_sum + w;
		if (col_sum > SUM_TOP)
			col_sum = SUM_TOP;
	endtask

	task automatic drop_sequence();
		seq_len = 3'd0;
		seq_got = 3'd0;
		seq_cp = '0;
	endtask

	// Handle a byte with no UTF-8 sequence open: escape tracking or a lead byte.
	task automatic scan_fresh(input logic [7:0] b);
		if (b == ESC_BYTE) begin
			txt_mode = MODE_ESC;
		end else if (txt_mode == MODE_ESC) begin
			if (b == CSI_BYTE)
				txt_mode = MODE_CSI;
			else if (b != KEEP_OPEN_A && b != KEEP_OPEN_B)
				txt_mode = MODE_TEXT;
		end else if (txt_mode == MODE_CSI) begin
			if (b != CSI_BYTE && b >= FINAL_LO && b <= FINAL_HI)
				txt_mode = MODE_TEXT;
		end else begin
			txt_mode = MODE_TEXT;
			if (b < 8'h80) begin
				add_cols(cell_cols({13'd0, b}));
			end else if (b[7:5] == 3'b110) begin
				seq_len = 3'd2;
				seq_got = 3'd1;
				seq_cp = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				seq_len = 3'd3;
				seq_got = 3'd1;
				seq_cp = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				seq_len = 3'd4;
				seq_got = 3'd1;
				seq_cp = {18'd0, b[2:0]};
			end else begin
				// stray continuation or 0xF8..0xFF seen as a lead
				add_cols(1);
			end
		end
	endtask

	// Advance the predictor by one accepted word; done flags a string total.
	task automatic advance_string(input word_t w, output bit done, output logic [15:0] total);
		cp_t least;
		done = 1'b0;
		total = '0;
		if (seq_len != 3'd0) begin
			if (w.b[7:6] == 2'b10) begin
				seq_cp = {seq_cp[14:0], w.b[5:0]};
				seq_got = seq_got + 3'd1;
				if (seq_got >= seq_len) begin
					least = seq_len == 3'd2 ? LEAST_TWO :
						seq_len == 3'd3 ? LEAST_THR : LEAST_FOUR;
					// overlong, above the code space, or a surrogate: one column a byte
					if (seq_cp < least || seq_cp > CP_MAX || in_span(seq_cp, SURR_LO, SURR_HI))
						add_cols(32'(seq_len));
					else
						add_cols(cell_cols(seq_cp));
					drop_sequence();
				end
			end else begin
				// broken sequence: charge its bytes, then treat this byte as new
				add_cols(32'(seq_got));
				drop_sequence();
				scan_fresh(w.b);
			end
		end else begin
			scan_fresh(w.b);
		end
		if (w.last) begin
			if (seq_len != 3'd0)
				add_cols(32'(seq_got));
			done = 1'b1;
			total = col_sum > 64'hFFFF ? TOTAL_MAX : col_sum[15:0];
			txt_mode = MODE_TEXT;
			drop_sequence();
			col_sum = 0;
		end
	endtask

	// Sender: hold the word while stalled, else advance or idle at the phase's rate.
	// Predict at the edge that accepts a word, from the word that was on the pins.
	always @(posedge clk) begin
		bit          done;
		logic [15:0] total;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				advance_string(cur_word, done, total);
				if (done)
					width_q.push_back(cur_word.typed ? cur_word.val : total);
			end
			if (!in_valid || !in_stall) begin
				if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_word = word_q.pop_front();
					in_valid <= 1'b1;
					text_byte <= cur_word.b;
					last_byte <= cur_word.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_ask != hold_served) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_ask;
		end else begin
			out_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	// Check every accepted total against the oldest expectation.
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (width_q.size() == 0) begin
				report_mismatch($sformatf("total %0d with none expected", total_width));
			end else begin
				want = width_q.pop_front();
				if (total_width !== want)
					report_mismatch($sformatf("total_width got %0d want %0d",
						total_width, want));
			end
		end
	end

	task automatic push_word(input logic [7:0] b);
		word_q.push_back('{b: b, last: 1'b0, typed: 1'b0, val: 16'd0});
	endtask

	// Push the first keep bytes of the len-byte form of cp (overlong when len is too big).
	task automatic push_utf8(input cp_t cp, input int len, input int keep);
		logic [7:0] enc[4];
		case (len)
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			push_word(enc[i]);
	endtask

	// Pick a code point of at least 0x80, biased toward wide and zero-width ranges.
	function automatic cp_t pick_cp();
		case ($urandom_range(0, 7))
			0: return 21'($urandom_range(21'h80, 21'h7FF));
			1: return 21'($urandom_range(21'h800, 21'hFFFF));
			2: return 21'($urandom_range(21'h10000, 21'h10FFFF));
			3: return 21'($urandom_range(21'h4E00, 21'h9FFF));
			4: return 21'($urandom_range(21'h1F300, 21'h1F64F));
			5: return 21'($urandom_range(21'h0300, 21'h036F));
			6: return 21'($urandom_range(21'hAC00, 21'hD7A3));
			default: return 21'($urandom_range(21'hE0100, 21'hE01EF));
		endcase
	endfunction

	// One token of text: mostly well-formed content, some malformed input and noise.
	task automatic push_token();
		int  pick;
		int  len;
		cp_t cp;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			push_word(8'($urandom_range(8'h20, 8'h7E)));
		end else if (pick < 48) begin
			cp = pick_cp();
			len = cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
			push_utf8(cp, len, len);
		end else if (pick < 58) begin
			push_word(ESC_BYTE);
			case ($urandom_range(0, 3))
				0: begin
					push_word(CSI_BYTE);
					repeat ($urandom_range(0, 3))
						push_word(8'($urandom_range(8'h30, 8'h3F)));
					push_word(8'($urandom_range(FINAL_LO, FINAL_HI)));
				end
				1: begin
					push_word($urandom_range(0, 1) ? KEEP_OPEN_A : KEEP_OPEN_B);
					push_word(8'($urandom_range(8'h30, 8'h42)));
				end
				2: push_word(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end else if (pick < 63) begin
			push_word(8'($urandom_range(8'h00, 8'h1F)));
		end else if (pick < 70) begin
			// overlong forms, surrogates and values above the code space
			case ($urandom_range(0, 4))
				0: push_utf8(21'($urandom_range(21'h0, 21'h7F)), 2, 2);
				1: push_utf8(21'($urandom_range(21'h0, 21'h7FF)), 3, 3);
				2: push_utf8(21'($urandom_range(21'h0, 21'hFFFF)), 4, 4);
				3: push_utf8(21'($urandom_range(SURR_LO, SURR_HI)), 3, 3);
				default: push_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
			endcase
		end else if (pick < 82) begin
			// truncated: only the first bytes of the form are pushed
			cp = pick_cp();
			len = cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
			push_utf8(cp, len, $urandom_range(1, len - 1));
		end else begin
			push_word(8'($urandom_range(0, 255)));
		end
	endtask

	// One string of random tokens, with last set on its final word.
	task automatic push_string(input int max_tokens);
		repeat ($urandom_range(1, max_tokens))
			push_token();
		word_q[word_q.size() - 1].last = 1'b1;
	endtask

	// Fill roughly nbytes of random strings.
	task automatic push_strings(input int nbytes);
		int start;
		start = word_q.size();
		while (word_q.size() - start < nbytes)
			push_string(8);
	endtask

	// Wait until every word is taken and every expected total has come back.
	task automatic drain();
		while (word_q.size() != 0 || in_valid || width_q.size() != 0)
			@(negedge clk);
	endtask

	// Directed strings; totals typed in where they are plain, zero-width mark left to
	// the predictor.
	word_t dir_tab [28] = '{
		'{8'h41, 1'b1, 1'b1, 16'd1},                              // lone 'A'
		'{8'h00, 1'b0, 1'b0, 16'd0}, '{8'h7F, 1'b1, 1'b1, 16'd0}, // controls
		'{8'hFF, 1'b1, 1'b1, 16'd1},                              // bad lead, top byte
		'{8'hC2, 1'b1, 1'b1, 16'd1},                              // open at end
		'{8'hCC, 1'b0, 1'b0, 16'd0}, '{8'h81, 1'b1, 1'b0, 16'd0}, // combining acute
		'{8'hC0, 1'b0, 1'b0, 16'd0}, '{8'h80, 1'b1, 1'b1, 16'd2}, // overlong
		'{8'hE4, 1'b0, 1'b0, 16'd0}, '{8'hB8, 1'b0, 1'b0, 16'd0},
		'{8'h80, 1'b1, 1'b1, 16'd2},                              // wide CJK
		'{8'hED, 1'b0, 1'b0, 16'd0}, '{8'hA0, 1'b0, 1'b0, 16'd0},
		'{8'h80, 1'b1, 1'b1, 16'd3},                              // surrogate
		'{8'hF4, 1'b0, 1'b0, 16'd0}, '{8'h90, 1'b0, 1'b0, 16'd0},
		'{8'h80, 1'b0, 1'b0, 16'd0}, '{8'h80, 1'b1, 1'b1, 16'd4}, // above 10FFFF
		'{8'h1B, 1'b0, 1'b0, 16'd0}, '{8'h5B, 1'b0, 1'b0, 16'd0},
		'{8'h6D, 1'b0, 1'b0, 16'd0}, '{8'h41, 1'b1, 1'b1, 16'd1}, // CSI then 'A'
		'{8'hE4, 1'b0, 1'b0, 16'd0}, '{8'h1B, 1'b0, 1'b0, 16'd0}, // ESC breaks it
		'{8'h28, 1'b0, 1'b0, 16'd0}, '{8'h42, 1'b0, 1'b0, 16'd0},
		'{8'h41, 1'b1, 1'b1, 16'd2}
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, no idling.
		foreach (dir_tab[i])
			word_q.push_back(dir_tab[i]);
		drain();

		// Random strings with no idling.
		push_strings(400);
		drain();

		// Hold off the receiver while short strings keep coming, so the input stalls.
		hold_ask = hold_ask + 1;
		repeat (50)
			push_string(2);
		drain();

		send_idle_pct = 81;
		push_strings(400);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 81;
		push_strings(400);
		drain();

		send_idle_pct = 9;
		recv_stall_pct = 9;
		push_strings(400);
		drain();

		// Let any stray total show up before the verdict.
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/uwd_pkg.sv
sv/uwd_cell_width.sv
sv/uwd_step.sv
sv/utf8_terminal_display_width.sv
sv/uwd_checker.sv
tb/tb_top.sv
